// File: rtl/core/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg
// shared types and constants of the gimbal end-stop calibration block
// ----------------------------------------------------------------------------
package gec_pkg;

  typedef enum logic [2:0] {
    PH_YAW_POS,
    PH_YAW_NEG,
    PH_PIT_POS,
    PH_PIT_NEG,
    PH_DONE
  } phase_t;

  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 31;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STILL_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_TICKS  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_CURRENT = 2'd2;

  localparam int unsigned STILL_WIDTH  = 31;
  localparam int unsigned SETTLE_WIDTH = 16;
  localparam int unsigned DRIVE_WIDTH  = 15;
  localparam int unsigned CMD_WIDTH    = 16;
  localparam int unsigned IO_WIDTH     = 32;

  localparam logic [STILL_WIDTH-1:0]  STILL_RESET  = 31'd65536;
  localparam logic [SETTLE_WIDTH-1:0] SETTLE_RESET = 16'd200;
  localparam logic [DRIVE_WIDTH-1:0]  DRIVE_RESET  = 15'd3000;

endpackage

// File: rtl/core/gimbal_endstop_calibration.sv
// ----------------------------------------------------------------------------
// gimbal_endstop_calibration
// finds the four mechanical end-stops of a yaw/pitch gimbal
// ----------------------------------------------------------------------------
// One input word per control tick carries the yaw and pitch encoder angles
// (signed Q16.16). Each word gives exactly one output word with the motor
// current commands, the calibrating and done flags, the four recorded limits
// and, once done, the floor midpoints of both axes.
// Both channels use valid/stall; a word moves when valid is high and stall is
// low. An input word is held in an input register, then one pass of compare,
// count and add logic updates the phase state and fills the output register.
// An accepted word passes through the input register and then the output
// register. Throughput is one word per cycle while out_stall is low. The
// output register frees as its word is taken, so a new input is accepted in
// the same cycle the previous result leaves.
// When the receiver stalls, the output word holds and the input register
// fills; in_stall then rises until the output drains.
// Reset restores the register defaults, returns to the yaw positive drive
// phase and clears the stall counter, the previous angles and all limits.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module gimbal_endstop_calibration #(
  parameter int unsigned ANGLE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [gec_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [gec_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gec_pkg::IO_WIDTH-1:0]   yaw_enc,
  input  logic signed [gec_pkg::IO_WIDTH-1:0]   pitch_enc,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gec_pkg::CMD_WIDTH-1:0]  yaw_drive,
  output logic signed [gec_pkg::CMD_WIDTH-1:0]  pitch_drive,
  output logic                                  calibrating,
  output logic                                  done_res,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   yaw_upper,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   yaw_lower,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   pitch_upper,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   pitch_lower,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   yaw_middle,
  output logic signed [gec_pkg::IO_WIDTH-1:0]   pitch_middle
);
  import gec_pkg::*;

  localparam int unsigned AW = ANGLE_WIDTH;
  localparam int unsigned XW = AW + IO_WIDTH;

  // configuration
  logic [STILL_WIDTH-1:0]  still_limit;
  logic [SETTLE_WIDTH-1:0] settle_ticks;
  logic [DRIVE_WIDTH-1:0]  drive_current;

  // input register
  logic                       in_reg_valid;
  logic signed [IO_WIDTH-1:0] in_reg_yaw;
  logic signed [IO_WIDTH-1:0] in_reg_pitch;

  // state
  phase_t                phase;
  phase_t                phase_next;
  logic [SETTLE_WIDTH-1:0] stall_count;
  logic [SETTLE_WIDTH-1:0] stall_count_next;
  logic signed [AW-1:0]  yaw_previous;
  logic signed [AW-1:0]  pitch_previous;
  logic signed [AW-1:0]  yaw_upper_limit;
  logic signed [AW-1:0]  yaw_lower_limit;
  logic signed [AW-1:0]  pitch_upper_limit;
  logic signed [AW-1:0]  pitch_lower_limit;
  logic signed [AW-1:0]  yaw_upper_limit_next;
  logic signed [AW-1:0]  yaw_lower_limit_next;
  logic signed [AW-1:0]  pitch_upper_limit_next;
  logic signed [AW-1:0]  pitch_lower_limit_next;

  // datapath
  logic                  out_free;
  logic                  step;
  logic [XW-1:0]         yaw_ext;
  logic [XW-1:0]         pitch_ext;
  logic signed [AW-1:0]  yaw_now;
  logic signed [AW-1:0]  pitch_now;
  logic signed [AW-1:0]  axis_now;
  logic signed [AW-1:0]  axis_prev;
  logic                  axis_still;
  logic [SETTLE_WIDTH-1:0] count_inc;
  logic                  settled;
  logic signed [CMD_WIDTH-1:0] drive_pos;
  logic signed [CMD_WIDTH-1:0] drive_neg;
  logic signed [CMD_WIDTH-1:0] yaw_drive_next;
  logic signed [CMD_WIDTH-1:0] pitch_drive_next;
  logic                  calibrating_next;
  logic                  done_next;
  logic [AW:0]           yaw_sum;
  logic [AW:0]           pitch_sum;
  logic signed [AW-1:0]  yaw_mid;
  logic signed [AW-1:0]  pitch_mid;
  logic [XW-1:0]         yaw_up_x;
  logic [XW-1:0]         yaw_lo_x;
  logic [XW-1:0]         pit_up_x;
  logic [XW-1:0]         pit_lo_x;
  logic [XW-1:0]         yaw_mid_x;
  logic [XW-1:0]         pit_mid_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      still_limit   <= STILL_RESET;
      settle_ticks  <= SETTLE_RESET;
      drive_current <= DRIVE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STILL_LIMIT:   still_limit   <= cfg_data[STILL_WIDTH-1:0];
        REG_SETTLE_TICKS:  settle_ticks  <= cfg_data[SETTLE_WIDTH-1:0];
        REG_DRIVE_CURRENT: drive_current <= cfg_data[DRIVE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign step     = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_yaw   <= yaw_enc;
      in_reg_pitch <= pitch_enc;
    end
  end

  // angle wrap to the internal width
  assign yaw_ext   = {{AW{in_reg_yaw[IO_WIDTH-1]}}, in_reg_yaw};
  assign pitch_ext = {{AW{in_reg_pitch[IO_WIDTH-1]}}, in_reg_pitch};
  assign yaw_now   = yaw_ext[AW-1:0];
  assign pitch_now = pitch_ext[AW-1:0];

  assign axis_now  = (phase == PH_YAW_POS || phase == PH_YAW_NEG) ? yaw_now : pitch_now;
  assign axis_prev = (phase == PH_YAW_POS || phase == PH_YAW_NEG) ? yaw_previous
                                                                  : pitch_previous;

  gec_stall_detect #(
    .ANGLE_WIDTH (AW)
  ) u_stall_detect (
    .now_angle   (axis_now),
    .prev_angle  (axis_prev),
    .still_limit (still_limit),
    .still       (axis_still)
  );

  assign count_inc = (stall_count == {SETTLE_WIDTH{1'b1}}) ? stall_count
                                                           : stall_count + SETTLE_WIDTH'(1);
  assign settled   = axis_still && (count_inc > settle_ticks);

  assign drive_pos = {1'b0, drive_current};
  assign drive_neg = -drive_pos;

  assign yaw_sum   = {yaw_upper_limit[AW-1], yaw_upper_limit}
                   + {yaw_lower_limit[AW-1], yaw_lower_limit};
  assign pitch_sum = {pitch_upper_limit[AW-1], pitch_upper_limit}
                   + {pitch_lower_limit[AW-1], pitch_lower_limit};
  assign yaw_mid   = yaw_sum[AW:1];
  assign pitch_mid = pitch_sum[AW:1];

  always_comb begin
    phase_next             = phase;
    stall_count_next       = stall_count;
    yaw_upper_limit_next   = yaw_upper_limit;
    yaw_lower_limit_next   = yaw_lower_limit;
    pitch_upper_limit_next = pitch_upper_limit;
    pitch_lower_limit_next = pitch_lower_limit;
    yaw_drive_next         = '0;
    pitch_drive_next       = '0;
    calibrating_next       = 1'b1;
    done_next              = 1'b0;
    if (axis_still) begin
      stall_count_next = settled ? '0 : count_inc;
    end
    case (phase)
      PH_YAW_POS: begin
        yaw_drive_next = drive_pos;
        if (settled) begin
          yaw_upper_limit_next = yaw_now;
          phase_next           = PH_YAW_NEG;
        end
      end
      PH_YAW_NEG: begin
        yaw_drive_next = drive_neg;
        if (settled) begin
          yaw_lower_limit_next = yaw_now;
          phase_next           = PH_PIT_POS;
        end
      end
      PH_PIT_POS: begin
        pitch_drive_next = drive_pos;
        if (settled) begin
          pitch_upper_limit_next = pitch_now;
          phase_next             = PH_PIT_NEG;
        end
      end
      PH_PIT_NEG: begin
        pitch_drive_next = drive_neg;
        if (settled) begin
          pitch_lower_limit_next = pitch_now;
          phase_next             = PH_DONE;
        end
      end
      default: begin
        stall_count_next = stall_count;
        phase_next       = PH_DONE;
        calibrating_next = 1'b0;
        done_next        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_YAW_POS;
      stall_count       <= '0;
      yaw_previous      <= '0;
      pitch_previous    <= '0;
      yaw_upper_limit   <= '0;
      yaw_lower_limit   <= '0;
      pitch_upper_limit <= '0;
      pitch_lower_limit <= '0;
    end else if (step) begin
      phase             <= phase_next;
      stall_count       <= stall_count_next;
      yaw_previous      <= yaw_now;
      pitch_previous    <= pitch_now;
      yaw_upper_limit   <= yaw_upper_limit_next;
      yaw_lower_limit   <= yaw_lower_limit_next;
      pitch_upper_limit <= pitch_upper_limit_next;
      pitch_lower_limit <= pitch_lower_limit_next;
    end
  end

  // widen to the port width, then keep the low word
  assign yaw_up_x  = {{IO_WIDTH{yaw_upper_limit_next[AW-1]}}, yaw_upper_limit_next};
  assign yaw_lo_x  = {{IO_WIDTH{yaw_lower_limit_next[AW-1]}}, yaw_lower_limit_next};
  assign pit_up_x  = {{IO_WIDTH{pitch_upper_limit_next[AW-1]}}, pitch_upper_limit_next};
  assign pit_lo_x  = {{IO_WIDTH{pitch_lower_limit_next[AW-1]}}, pitch_lower_limit_next};
  assign yaw_mid_x = done_next ? {{IO_WIDTH{yaw_mid[AW-1]}}, yaw_mid} : '0;
  assign pit_mid_x = done_next ? {{IO_WIDTH{pitch_mid[AW-1]}}, pitch_mid} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      yaw_drive    <= yaw_drive_next;
      pitch_drive  <= pitch_drive_next;
      calibrating  <= calibrating_next;
      done_res     <= done_next;
      yaw_upper    <= yaw_up_x[IO_WIDTH-1:0];
      yaw_lower    <= yaw_lo_x[IO_WIDTH-1:0];
      pitch_upper  <= pit_up_x[IO_WIDTH-1:0];
      pitch_lower  <= pit_lo_x[IO_WIDTH-1:0];
      yaw_middle   <= yaw_mid_x[IO_WIDTH-1:0];
      pitch_middle <= pit_mid_x[IO_WIDTH-1:0];
    end
  end

endmodule

// File: rtl/core/gec_stall_detect.sv
// ----------------------------------------------------------------------------
// gec_stall_detect
// flags an axis as still when |now - prev| is strictly below the limit
// ----------------------------------------------------------------------------
module gec_stall_detect #(
  parameter int unsigned ANGLE_WIDTH = 32
) (
  input  logic signed [ANGLE_WIDTH-1:0]      now_angle,
  input  logic signed [ANGLE_WIDTH-1:0]      prev_angle,
  input  logic [gec_pkg::STILL_WIDTH-1:0]    still_limit,
  output logic                               still
);
  import gec_pkg::*;

  localparam int unsigned DW = ANGLE_WIDTH + 1;
  localparam int unsigned CW = (DW > STILL_WIDTH) ? DW : STILL_WIDTH;

  logic [DW-1:0] diff;
  logic [DW-1:0] mag;
  logic [CW-1:0] mag_ext;
  logic [CW-1:0] limit_ext;

  assign diff      = {now_angle[ANGLE_WIDTH-1], now_angle}
                   - {prev_angle[ANGLE_WIDTH-1], prev_angle};
  assign mag       = diff[DW-1] ? (~diff + DW'(1)) : diff;
  assign mag_ext   = CW'(mag);
  assign limit_ext = CW'(still_limit);
  assign still     = mag_ext < limit_ext;

endmodule
